[rtl/dgq_pkg.sv]
// dgq_pkg: shared constants, register codes, state and struct types for
// the diagonal green quadrature block. No dependencies.
package dgq_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int H_W        = 31;
	localparam int DECAY_W    = 25;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 31;
	localparam logic [DECAY_W-1:0] ONE_Q24 = DECAY_W'(1 << 24);
	localparam logic [63:0] HALF_Q24 = 64'd8388608;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEP_H = 1'b0,
		REG_DECAY  = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MSEL_CONTRIB,
		MSEL_SUM,
		MSEL_RESULT
	} mul_sel_t;

	typedef enum logic [4:0] {
		S_LOAD,
		S_FLUSH,
		S_DSTART,
		S_ISSUE,
		S_DRAIN,
		S_SC_LO,
		S_SC_HI,
		S_SC_FIN,
		S_ACC,
		S_CHECK,
		S_H1_LO,
		S_H1_HI,
		S_H1_FIN,
		S_H2_LO,
		S_H2_HI,
		S_H2_FIN,
		S_OUT
	} state_t;

	typedef struct packed {
		logic              load;
		logic              sweep_init;
		logic              diag_init;
		logic              issue;
		logic              first_growing;
		logic [ADDR_W-1:0] pa;
		logic [ADDR_W-1:0] pb;
		logic              mul_lo;
		logic              mul_hi;
		logic              mul_fin;
		mul_sel_t          mul_sel;
		logic              acc_sum;
		logic              out_load;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic             pipe_busy;
		logic             conv;
		logic             out_busy;
	} status_t;

endpackage

[rtl/dgq_if.sv]
// dgq_if: valid/ready channel interfaces for points, results and config writes
// depends on dgq_pkg
interface dgq_in_if;
	import dgq_pkg::*;
	logic               valid;
	logic               ready;
	logic signed [31:0] final_wave;
	logic signed [31:0] final_potential;
	logic signed [31:0] initial_wave;
	logic signed [31:0] initial_potential;
	logic signed [31:0] growing_green;
	logic signed [31:0] decaying_green;
	logic               last_point;
	modport source(output valid, final_wave, final_potential, initial_wave,
		initial_potential, growing_green, decaying_green, last_point, input ready);
	modport sink(input valid, final_wave, final_potential, initial_wave,
		initial_potential, growing_green, decaying_green, last_point, output ready);
endinterface

interface dgq_out_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] integral_value;
	logic               saturated;
	modport source(output valid, integral_value, saturated, input ready);
	modport sink(input valid, integral_value, saturated, output ready);
endinterface

interface dgq_cfg_if;
	import dgq_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[rtl/diagonal_green_quadrature.sv]
// diagonal_green_quadrature: top level joining the sequencer and the datapath
// depends on dgq_pkg, dgq_if, dgq_ctrl, dgq_dp
//
// Grid points load one beat per cycle into four 1024-entry stores. The beat
// flagged last_point starts the sweep: for n stored points and diagonals
// d = 0 .. D-1 (D at most n/2, fewer on early convergence) the term
// pipeline reads one term per cycle from the dual-read stores, n terms
// for d = 0 and 2(n-d) for each d > 0; each diagonal sum is then weighted
// by the decay weight and added to the total, which is scaled twice by the
// grid step. New points are not taken during the sweep.
// A finished result waits in an output register while the next data set
// loads. Stores need no clearing after reset.
module diagonal_green_quadrature (
	input  logic     clk,
	input  logic     arst_n,
	dgq_in_if.sink   points,
	dgq_out_if.source result,
	dgq_cfg_if.sink  cfg
);
	import dgq_pkg::*;

	cmd_t    cmd;
	status_t sts;
	logic    in_ready;

	assign points.ready = in_ready;

	dgq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (points.valid),
		.in_last  (points.last_point),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dgq_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.final_wave        (points.final_wave),
		.final_potential   (points.final_potential),
		.initial_wave      (points.initial_wave),
		.initial_potential (points.initial_potential),
		.growing_green     (points.growing_green),
		.decaying_green    (points.decaying_green),
		.cfg               (cfg),
		.result            (result)
	);

endmodule

[rtl/dgq_ctrl.sv]
// dgq_ctrl: sequencer for loading, the diagonal sweep and the final scaling
// depends on dgq_pkg
module dgq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_ready,
	input  dgq_pkg::status_t  sts,
	output dgq_pkg::cmd_t     cmd
);
	import dgq_pkg::*;

	state_t           state_q, state_nx;
	logic [CNT_W-1:0] d_q, d_nx;
	logic [CNT_W-1:0] k_q, k_nx;
	logic             phase_b_q, phase_b_nx;
	logic [CNT_W-1:0] last_d;
	logic [CNT_W-1:0] len;
	logic [CNT_W-1:0] kd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			d_q       <= '0;
			k_q       <= '0;
			phase_b_q <= 1'b0;
		end else begin
			state_q   <= state_nx;
			d_q       <= d_nx;
			k_q       <= k_nx;
			phase_b_q <= phase_b_nx;
		end
	end

	assign last_d = sts.cnt >> 1;
	assign len    = sts.cnt - d_q;
	assign kd     = k_q + d_q;

	always_comb begin
		state_nx   = state_q;
		d_nx       = d_q;
		k_nx       = k_q;
		phase_b_nx = phase_b_q;
		cmd        = '0;
		cmd.mul_sel = MSEL_CONTRIB;
		in_ready   = 1'b0;
		case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_last) state_nx = S_FLUSH;
				end
			end
			S_FLUSH: begin
				cmd.sweep_init = 1'b1;
				d_nx = '0;
				state_nx = (last_d == '0) ? S_H1_LO : S_DSTART;
			end
			S_DSTART: begin
				cmd.diag_init = 1'b1;
				k_nx       = '0;
				phase_b_nx = 1'b0;
				state_nx   = S_ISSUE;
			end
			S_ISSUE: begin
				cmd.issue          = 1'b1;
				cmd.first_growing  = !phase_b_q;
				cmd.pa = phase_b_q ? kd[ADDR_W-1:0] : k_q[ADDR_W-1:0];
				cmd.pb = phase_b_q ? k_q[ADDR_W-1:0] : kd[ADDR_W-1:0];
				if (k_q == len - CNT_W'(1)) begin
					k_nx = '0;
					if (!phase_b_q && d_q != '0) phase_b_nx = 1'b1;
					else state_nx = S_DRAIN;
				end else begin
					k_nx = k_q + CNT_W'(1);
				end
			end
			S_DRAIN: begin
				if (!sts.pipe_busy) state_nx = S_SC_LO;
			end
			S_SC_LO: begin
				cmd.mul_lo = 1'b1;
				state_nx = S_SC_HI;
			end
			S_SC_HI: begin
				cmd.mul_hi = 1'b1;
				state_nx = S_SC_FIN;
			end
			S_SC_FIN: begin
				cmd.mul_fin = 1'b1;
				state_nx = S_ACC;
			end
			S_ACC: begin
				cmd.acc_sum = 1'b1;
				state_nx = S_CHECK;
			end
			S_CHECK: begin
				if (sts.conv || (d_q + CNT_W'(1)) == last_d) begin
					state_nx = S_H1_LO;
				end else begin
					d_nx = d_q + CNT_W'(1);
					state_nx = S_DSTART;
				end
			end
			S_H1_LO: begin
				cmd.mul_lo = 1'b1;
				cmd.mul_sel = MSEL_SUM;
				state_nx = S_H1_HI;
			end
			S_H1_HI: begin
				cmd.mul_hi = 1'b1;
				cmd.mul_sel = MSEL_SUM;
				state_nx = S_H1_FIN;
			end
			S_H1_FIN: begin
				cmd.mul_fin = 1'b1;
				cmd.mul_sel = MSEL_SUM;
				state_nx = S_H2_LO;
			end
			S_H2_LO: begin
				cmd.mul_lo = 1'b1;
				cmd.mul_sel = MSEL_RESULT;
				state_nx = S_H2_HI;
			end
			S_H2_HI: begin
				cmd.mul_hi = 1'b1;
				cmd.mul_sel = MSEL_RESULT;
				state_nx = S_H2_FIN;
			end
			S_H2_FIN: begin
				cmd.mul_fin = 1'b1;
				cmd.mul_sel = MSEL_RESULT;
				state_nx = S_OUT;
			end
			S_OUT: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_nx = S_LOAD;
				end
			end
			default: state_nx = S_LOAD;
		endcase
	end

endmodule

[rtl/dgq_dp.sv]
// dgq_dp: sample stores, term pipeline, accumulators, scaling multiplier,
// config registers and result register; depends on dgq_pkg and dgq_if
module dgq_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  dgq_pkg::cmd_t      cmd,
	output dgq_pkg::status_t   sts,
	input  logic signed [31:0] final_wave,
	input  logic signed [31:0] final_potential,
	input  logic signed [31:0] initial_wave,
	input  logic signed [31:0] initial_potential,
	input  logic signed [31:0] growing_green,
	input  logic signed [31:0] decaying_green,
	dgq_cfg_if.sink            cfg,
	dgq_out_if.source          result
);
	import dgq_pkg::*;

	typedef struct packed {
		logic [31:0] val;
		logic        sat;
	} r32_t;

	typedef struct packed {
		logic [63:0] val;
		logic        sat;
	} r64_t;

	function automatic r32_t pair_q24(input logic [63:0] p);
		logic [63:0] mg;
		logic [39:0] m;
		r32_t        r;
		mg = p[63] ? (64'd0 - p) : p;
		m  = 40'((mg + HALF_Q24) >> 24);
		r.sat = 1'b0;
		if (p[63]) begin
			if (m > 40'h0080000000) begin
				r.sat = 1'b1;
				m = 40'h0080000000;
			end
			r.val = 32'd0 - m[31:0];
		end else begin
			if (m > 40'h007FFFFFFF) begin
				r.sat = 1'b1;
				m = 40'h007FFFFFFF;
			end
			r.val = m[31:0];
		end
		return r;
	endfunction

	function automatic r64_t sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] s;
		r64_t        r;
		s = a + b;
		r.sat = (a[63] == b[63]) && (s[63] != a[63]);
		r.val = r.sat ? (a[63] ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF) : s;
		return r;
	endfunction

	function automatic logic [63:0] mag64(input logic [63:0] a);
		return a[63] ? (64'd0 - a) : a;
	endfunction

	// config
	logic [H_W-1:0]     h_q;
	logic [DECAY_W-1:0] decay_q;
	logic [DECAY_W-1:0] decay_c;

	// load path
	logic [CNT_W-1:0]   cnt_q;
	logic signed [63:0] pf_s1, pi_s1;
	logic signed [31:0] gg_s1, gd_s1;
	logic               we_s1;
	logic [ADDR_W-1:0]  wa_s1;
	r32_t               pf_r, pi_r;

	// stores
	logic signed [31:0] fp_mem [MAX_POINTS];
	logic signed [31:0] ip_mem [MAX_POINTS];
	logic signed [31:0] gg_mem [MAX_POINTS];
	logic signed [31:0] gd_mem [MAX_POINTS];

	// term pipeline
	logic               vs1, vs2, vs3, vs4;
	logic               fg_s1;
	logic signed [31:0] fpa_s1, ipb_s1, gga_s1, ggb_s1, gda_s1, gdb_s1;
	logic signed [31:0] ga, gb;
	logic signed [63:0] pu_s2, pv_s2;
	r32_t               u_r, v_r;
	logic signed [31:0] u_s3, v_s3;
	logic signed [63:0] t_s4;
	logic [63:0]        c_q;
	r64_t               c_add;

	// scaling multiplier and sums
	logic [63:0]        mop;
	logic [31:0]        mw;
	logic [63:0]        mop_mag;
	logic [63:0]        mlo_q, mhi_q;
	logic               msign_q;
	logic [63:0]        mres_q;
	logic [63:0]        lo_rnd, r_raw, lim;
	logic               hsat;
	logic [63:0]        r_lim;
	logic               r_sat;
	logic [63:0]        sum_q;
	r64_t               sum_add;
	logic [DECAY_W-1:0] w_q;
	logic [2*DECAY_W-1:0] w_prod;

	// status and output
	logic               sat_q;
	logic               out_valid_q;
	logic signed [63:0] out_val_q;
	logic               out_sat_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q     <= '0;
			decay_q <= ONE_Q24;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_STEP_H: h_q <= cfg.data[H_W-1:0];
				REG_DECAY:  decay_q <= cfg.data[DECAY_W-1:0];
				default:    ;
			endcase
		end
	end

	assign decay_c = (decay_q > ONE_Q24) ? ONE_Q24 : decay_q;

	// load: products then round and write
	always_ff @(posedge clk) begin
		pf_s1 <= final_wave * final_potential;
		pi_s1 <= initial_wave * initial_potential;
		gg_s1 <= growing_green;
		gd_s1 <= decaying_green;
		wa_s1 <= cnt_q[ADDR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			we_s1 <= 1'b0;
			cnt_q <= '0;
		end else begin
			we_s1 <= cmd.load && (cnt_q < CNT_W'(MAX_POINTS));
			if (cmd.out_load) cnt_q <= '0;
			else if (cmd.load && (cnt_q < CNT_W'(MAX_POINTS))) cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	assign pf_r = pair_q24(pf_s1);
	assign pi_r = pair_q24(pi_s1);

	always_ff @(posedge clk) begin
		if (we_s1) begin
			fp_mem[wa_s1] <= pf_r.val;
			ip_mem[wa_s1] <= pi_r.val;
			gg_mem[wa_s1] <= gg_s1;
			gd_mem[wa_s1] <= gd_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			fpa_s1 <= fp_mem[cmd.pa];
			ipb_s1 <= ip_mem[cmd.pb];
			gga_s1 <= gg_mem[cmd.pa];
			ggb_s1 <= gg_mem[cmd.pb];
			gda_s1 <= gd_mem[cmd.pa];
			gdb_s1 <= gd_mem[cmd.pb];
			fg_s1  <= cmd.first_growing;
		end
	end

	assign ga = fg_s1 ? gga_s1 : gda_s1;
	assign gb = fg_s1 ? gdb_s1 : ggb_s1;

	assign u_r = pair_q24(pu_s2);
	assign v_r = pair_q24(pv_s2);

	always_ff @(posedge clk) begin
		pu_s2 <= fpa_s1 * ga;
		pv_s2 <= ipb_s1 * gb;
		u_s3  <= u_r.val;
		v_s3  <= v_r.val;
		t_s4  <= u_s3 * v_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vs1 <= 1'b0;
			vs2 <= 1'b0;
			vs3 <= 1'b0;
			vs4 <= 1'b0;
		end else begin
			vs1 <= cmd.issue;
			vs2 <= vs1;
			vs3 <= vs2;
			vs4 <= vs3;
		end
	end

	assign c_add = sat_add(c_q, t_s4);

	always_ff @(posedge clk) begin
		if (cmd.diag_init) c_q <= '0;
		else if (vs4) c_q <= c_add.val;
	end

	// scaling multiplier: round(a * w / 2^24) in three steps
	always_comb begin
		case (cmd.mul_sel)
			MSEL_CONTRIB: begin
				mop = c_q;
				mw  = 32'(w_q);
			end
			MSEL_SUM: begin
				mop = sum_q;
				mw  = 32'(h_q);
			end
			MSEL_RESULT: begin
				mop = mres_q;
				mw  = 32'(h_q);
			end
			default: begin
				mop = mres_q;
				mw  = 32'(h_q);
			end
		endcase
	end

	assign mop_mag = mag64(mop);
	assign lo_rnd  = (mlo_q + HALF_Q24) >> 24;
	assign hsat    = |mhi_q[63:56];
	assign r_raw   = hsat ? '1 : ((mhi_q << 8) + lo_rnd);
	assign lim     = msign_q ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
	assign r_sat   = hsat || (r_raw > lim);
	assign r_lim   = (r_raw > lim) ? lim : r_raw;

	always_ff @(posedge clk) begin
		if (cmd.mul_lo) begin
			mlo_q   <= mop_mag[31:0] * mw;
			msign_q <= mop[63];
		end
		if (cmd.mul_hi) mhi_q <= mop_mag[63:32] * mw;
		if (cmd.mul_fin) mres_q <= msign_q ? (64'd0 - r_lim) : r_lim;
	end

	assign sum_add = sat_add(sum_q, mres_q);
	assign w_prod  = w_q * decay_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= ONE_Q24;
		end else if (cmd.sweep_init) begin
			w_q <= ONE_Q24;
		end else if (cmd.acc_sum) begin
			w_q <= DECAY_W'((w_prod + (2*DECAY_W)'(HALF_Q24)) >> 24);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep_init) sum_q <= '0;
		else if (cmd.acc_sum) sum_q <= sum_add.val;
	end

	// sticky saturation over one data set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
		end else if (cmd.out_load) begin
			sat_q <= 1'b0;
		end else if ((we_s1 && (pf_r.sat || pi_r.sat)) || (vs2 && (u_r.sat || v_r.sat))
			|| (vs4 && c_add.sat) || (cmd.acc_sum && sum_add.sat) || (cmd.mul_fin && r_sat)) begin
			sat_q <= 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_val_q <= mres_q;
			out_sat_q <= sat_q;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.integral_value = out_val_q;
	assign result.saturated      = out_sat_q;

	assign sts.cnt       = cnt_q;
	assign sts.pipe_busy = vs1 | vs2 | vs3 | vs4;
	assign sts.conv      = mag64(mres_q) < (mag64(sum_q) >> 33);
	assign sts.out_busy  = out_valid_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_POINTS))
		else $error("point count above store depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (CNT_W'(cmd.pa) < cnt_q) && (CNT_W'(cmd.pb) < cnt_q))
		else $error("term read beyond loaded points");

	assert property (@(posedge clk) disable iff (!arst_n)
		w_q <= ONE_Q24)
		else $error("diagonal weight above one");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_lo |-> !sts.pipe_busy)
		else $error("scaling started with terms in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !we_s1)
		else $error("result loaded while a point is being stored");

endmodule
